[hw/rtl/orbo_pkg.sv]
// Shared constants, item word type and sine table builder for the overlap test.
package orbo_pkg;

    localparam int COORD_BITS  = 16;
    localparam int LEN_BITS    = COORD_BITS - 1;
    localparam int ANG_BITS    = 16;
    localparam int TRIG_BITS   = 16;
    localparam int SIN_ENTRIES = 1024;
    localparam int ABITS       = $clog2(SIN_ENTRIES);
    localparam int QDEPTH      = 4;
    localparam int QAW         = $clog2(QDEPTH);
    localparam int QCW         = QAW + 1;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic signed [TRIG_BITS-1:0] t_sin_rom [SIN_ENTRIES];

    typedef struct packed {
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic        [LEN_BITS-1:0]   w;
        logic        [LEN_BITS-1:0]   h;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic        [LEN_BITS-1:0]   bw;
        logic        [LEN_BITS-1:0]   bh;
        logic signed [TRIG_BITS-1:0]  s;
        logic signed [TRIG_BITS-1:0]  c;
        logic        [3:0]            use_axis;
    } t_item;

    // Quadrant fold plus 11th-order Taylor series in Q30, rounded to Q14.
    function automatic logic signed [TRIG_BITS-1:0] sine_q14(input logic [31:0] ph);
        logic [63:0] r;
        logic [63:0] theta;
        logic [63:0] t2;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] mag;
        r = {34'd0, ph[29:0]};
        if (ph[30]) begin
            r = Q30_ONE - r;
        end
        theta = (r * HALF_PI_Q30) >> 30;
        t2    = (theta * theta) >> 30;
        p     = Q30_ONE;
        p     = Q30_ONE - (((t2 * p) >> 30) / 64'd110);
        p     = Q30_ONE - (((t2 * p) >> 30) / 64'd72);
        p     = Q30_ONE - (((t2 * p) >> 30) / 64'd42);
        p     = Q30_ONE - (((t2 * p) >> 30) / 64'd20);
        p     = Q30_ONE - (((t2 * p) >> 30) / 64'd6);
        s     = (theta * p) >> 30;
        mag   = (s + 64'd32768) >> 16;
        return ph[31] ? TRIG_BITS'(-mag) : TRIG_BITS'(mag);
    endfunction

    function automatic t_sin_rom build_sin_rom();
        t_sin_rom rom;
        for (int i = 0; i < SIN_ENTRIES; i++) begin
            rom[i] = sine_q14(32'(i) << (32 - ABITS));
        end
        return rom;
    endfunction

endpackage

[hw/rtl/oriented_rect_box_overlap_top.sv]
// Top level of the rotated-rectangle versus box overlap tester.
//
// Usage: drive one shape pair on the i_ field ports and raise start; the
// word is taken at a rising edge where start is high and busy is low.
// A new word may be taken every cycle.
// The rotated rectangle is given by centre, full width, full height and a
// binary angle; the box by its minimum corner, width and height, all in
// signed Q12.4 or unsigned Q11.4. The angle indexes a 1024-entry sine table.
// Each word yields exactly one result: o_overlap is valid for the single
// cycle in which o_strobe is high, and results come out in order.
// Throughput is one word per cycle, set by the fully pipelined back end.
// The front end registers the word and reads sine and cosine from the
// table; a four-entry queue separates it from the back end, which drains
// one word per cycle, so busy stays low in normal use.
// The receiver cannot stall; results are never held.
// Reset (i_rst_n low at a clock edge) empties the queue and the pipeline;
// no results come out for words accepted before reset.
module oriented_rect_box_overlap_top import orbo_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_obb_center_x,
    input  logic signed [COORD_BITS-1:0] i_obb_center_y,
    input  logic        [LEN_BITS-1:0]   i_obb_width,
    input  logic        [LEN_BITS-1:0]   i_obb_height,
    input  logic        [ANG_BITS-1:0]   i_obb_angle,
    input  logic signed [COORD_BITS-1:0] i_box_x,
    input  logic signed [COORD_BITS-1:0] i_box_y,
    input  logic        [LEN_BITS-1:0]   i_box_width,
    input  logic        [LEN_BITS-1:0]   i_box_height,
    output logic                         o_strobe,
    output logic                         o_overlap
);

    logic           w_accept;
    t_item          w_front_word;
    logic           w_front_valid;
    t_item          w_queue_word;
    logic [QCW-1:0] w_count;
    logic           w_pop;

    assign w_accept = start && !busy;
    assign busy     = (w_count + QCW'(w_front_valid)) >= QCW'(QDEPTH);
    assign w_pop    = w_count != '0;

    orbo_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_obb_center_x (i_obb_center_x),
        .i_obb_center_y (i_obb_center_y),
        .i_obb_width    (i_obb_width),
        .i_obb_height   (i_obb_height),
        .i_obb_angle    (i_obb_angle),
        .i_box_x        (i_box_x),
        .i_box_y        (i_box_y),
        .i_box_width    (i_box_width),
        .i_box_height   (i_box_height),
        .o_word         (w_front_word),
        .o_valid        (w_front_valid)
    );

    orbo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_word  (w_front_word),
        .i_pop   (w_pop),
        .o_word  (w_queue_word),
        .o_count (w_count)
    );

    orbo_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_pop),
        .i_word    (w_queue_word),
        .o_strobe  (o_strobe),
        .o_overlap (o_overlap)
    );

endmodule

[hw/rtl/orbo_front.sv]
// Front end: captures a shape pair, looks up sine and cosine, flags usable axes.
module orbo_front import orbo_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic signed [COORD_BITS-1:0] i_obb_center_x,
    input  logic signed [COORD_BITS-1:0] i_obb_center_y,
    input  logic        [LEN_BITS-1:0]   i_obb_width,
    input  logic        [LEN_BITS-1:0]   i_obb_height,
    input  logic        [ANG_BITS-1:0]   i_obb_angle,
    input  logic signed [COORD_BITS-1:0] i_box_x,
    input  logic signed [COORD_BITS-1:0] i_box_y,
    input  logic        [LEN_BITS-1:0]   i_box_width,
    input  logic        [LEN_BITS-1:0]   i_box_height,
    output t_item                        o_word,
    output logic                         o_valid
);

    localparam t_sin_rom SIN_ROM = build_sin_rom();

    logic [ABITS-1:0] w_sin_addr;
    logic [ABITS-1:0] w_cos_addr;
    logic             r_valid;
    t_item            r_word;

    assign w_sin_addr = i_obb_angle[ANG_BITS-1 -: ABITS];
    assign w_cos_addr = w_sin_addr + ABITS'(SIN_ENTRIES / 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_word.cx       <= i_obb_center_x;
            r_word.cy       <= i_obb_center_y;
            r_word.w        <= i_obb_width;
            r_word.h        <= i_obb_height;
            r_word.bx       <= i_box_x;
            r_word.by       <= i_box_y;
            r_word.bw       <= i_box_width;
            r_word.bh       <= i_box_height;
            r_word.s        <= SIN_ROM[w_sin_addr];
            r_word.c        <= SIN_ROM[w_cos_addr];
            r_word.use_axis <= {i_box_height != '0, i_box_width != '0,
                                i_obb_height != '0, i_obb_width != '0};
        end
    end

    assign o_word  = r_word;
    assign o_valid = r_valid;

endmodule

[hw/rtl/orbo_queue.sv]
// Short FIFO between the front end and the test pipeline.
module orbo_queue import orbo_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  t_item          i_word,
    input  logic           i_pop,
    output t_item          o_word,
    output logic [QCW-1:0] o_count
);

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QCW-1:0] r_count;
    logic [QCW-1:0] n_count;

    assign n_count = r_count + QCW'(i_push) - QCW'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

    assign o_word  = r_mem[r_rd];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> r_count < QCW'(QDEPTH))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue underflow");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + QCW'(1))
        else $error("queue count mismatch");

endmodule

[hw/rtl/orbo_back.sv]
// Test pipeline: corners, axis projections, interval compares, overlap flag.
module orbo_back import orbo_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_word,
    output logic  o_strobe,
    output logic  o_overlap
);

    localparam int RPW = LEN_BITS + 1 + TRIG_BITS;
    localparam int XW  = COORD_BITS + 17;
    localparam int BXW = COORD_BITS + 1;
    localparam int PW  = XW + TRIG_BITS;
    localparam int BPW = BXW + TRIG_BITS;
    localparam int DW  = PW + 1;

    function automatic logic signed [DW-1:0] min2(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [DW-1:0] max2(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    // stage 1: rotation products
    logic                          r1_v;
    logic signed [RPW-1:0]         r1_pa, r1_pb, r1_pc, r1_pd;
    logic signed [COORD_BITS-1:0]  r1_cx, r1_cy, r1_bx, r1_by;
    logic signed [BXW-1:0]         r1_bx1, r1_by1;
    logic signed [TRIG_BITS-1:0]   r1_s, r1_c;
    logic [3:0]                    r1_use;
    logic signed [LEN_BITS:0]      w_w, w_h, w_bw, w_bh;

    assign w_w  = signed'({1'b0, i_word.w});
    assign w_h  = signed'({1'b0, i_word.h});
    assign w_bw = signed'({1'b0, i_word.bw});
    assign w_bh = signed'({1'b0, i_word.bh});

    always_ff @(posedge i_clk) begin
        r1_pa  <= RPW'(w_w) * RPW'(i_word.c);
        r1_pb  <= RPW'(w_h) * RPW'(i_word.s);
        r1_pc  <= RPW'(w_w) * RPW'(i_word.s);
        r1_pd  <= RPW'(w_h) * RPW'(i_word.c);
        r1_cx  <= i_word.cx;
        r1_cy  <= i_word.cy;
        r1_bx  <= i_word.bx;
        r1_by  <= i_word.by;
        r1_bx1 <= BXW'(i_word.bx) + BXW'(w_bw);
        r1_by1 <= BXW'(i_word.by) + BXW'(w_bh);
        r1_s   <= i_word.s;
        r1_c   <= i_word.c;
        r1_use <= i_word.use_axis;
    end

    // stage 2: corners of the rotated rectangle
    logic                        r2_v;
    logic signed [XW-1:0]        r2_x [4];
    logic signed [XW-1:0]        r2_y [4];
    logic signed [BXW-1:0]       r2_bx0, r2_bx1, r2_by0, r2_by1;
    logic signed [TRIG_BITS-1:0] r2_s, r2_c;
    logic [3:0]                  r2_use;
    logic signed [XW-1:0]        w_cxs, w_cys, w_pa, w_pb, w_pc, w_pd;

    assign w_cxs = XW'(r1_cx) <<< 15;
    assign w_cys = XW'(r1_cy) <<< 15;
    assign w_pa  = XW'(r1_pa);
    assign w_pb  = XW'(r1_pb);
    assign w_pc  = XW'(r1_pc);
    assign w_pd  = XW'(r1_pd);

    always_ff @(posedge i_clk) begin
        r2_x[0] <= w_cxs - w_pa + w_pb;
        r2_y[0] <= w_cys - w_pc - w_pd;
        r2_x[1] <= w_cxs + w_pa + w_pb;
        r2_y[1] <= w_cys + w_pc - w_pd;
        r2_x[2] <= w_cxs + w_pa - w_pb;
        r2_y[2] <= w_cys + w_pc + w_pd;
        r2_x[3] <= w_cxs - w_pa - w_pb;
        r2_y[3] <= w_cys - w_pc + w_pd;
        r2_bx0  <= BXW'(r1_bx);
        r2_by0  <= BXW'(r1_by);
        r2_bx1  <= r1_bx1;
        r2_by1  <= r1_by1;
        r2_s    <= r1_s;
        r2_c    <= r1_c;
        r2_use  <= r1_use;
    end

    // stage 3: projection products, box-axis extents of the rotated rectangle
    logic                  r3_v;
    logic signed [PW-1:0]  r3_m0x [4];
    logic signed [PW-1:0]  r3_m0y [4];
    logic signed [PW-1:0]  r3_m1x [4];
    logic signed [PW-1:0]  r3_m1y [4];
    logic signed [BPW-1:0] r3_bxc0, r3_bxc1, r3_bys0, r3_bys1;
    logic signed [BPW-1:0] r3_bxs0, r3_bxs1, r3_byc0, r3_byc1;
    logic signed [DW-1:0]  r3_xmin, r3_xmax, r3_ymin, r3_ymax;
    logic signed [DW-1:0]  r3_bl, r3_br, r3_bt, r3_bb;
    logic [3:0]            r3_use;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r3_m0x[i] <= PW'(r2_x[i]) * PW'(r2_c);
            r3_m0y[i] <= PW'(r2_y[i]) * PW'(r2_s);
            r3_m1x[i] <= PW'(r2_x[i]) * PW'(r2_s);
            r3_m1y[i] <= PW'(r2_y[i]) * PW'(r2_c);
        end
        r3_bxc0 <= BPW'(r2_bx0) * BPW'(r2_c);
        r3_bxc1 <= BPW'(r2_bx1) * BPW'(r2_c);
        r3_bys0 <= BPW'(r2_by0) * BPW'(r2_s);
        r3_bys1 <= BPW'(r2_by1) * BPW'(r2_s);
        r3_bxs0 <= BPW'(r2_bx0) * BPW'(r2_s);
        r3_bxs1 <= BPW'(r2_bx1) * BPW'(r2_s);
        r3_byc0 <= BPW'(r2_by0) * BPW'(r2_c);
        r3_byc1 <= BPW'(r2_by1) * BPW'(r2_c);
        r3_xmin <= min2(min2(DW'(r2_x[0]), DW'(r2_x[1])), min2(DW'(r2_x[2]), DW'(r2_x[3])));
        r3_xmax <= max2(max2(DW'(r2_x[0]), DW'(r2_x[1])), max2(DW'(r2_x[2]), DW'(r2_x[3])));
        r3_ymin <= min2(min2(DW'(r2_y[0]), DW'(r2_y[1])), min2(DW'(r2_y[2]), DW'(r2_y[3])));
        r3_ymax <= max2(max2(DW'(r2_y[0]), DW'(r2_y[1])), max2(DW'(r2_y[2]), DW'(r2_y[3])));
        r3_bl   <= DW'(r2_bx0) <<< 15;
        r3_br   <= DW'(r2_bx1) <<< 15;
        r3_bt   <= DW'(r2_by0) <<< 15;
        r3_bb   <= DW'(r2_by1) <<< 15;
        r3_use  <= r2_use;
    end

    // stage 4: dot products, box intervals, box-axis compares
    logic                 r4_v;
    logic signed [DW-1:0] r4_d0 [4];
    logic signed [DW-1:0] r4_d1 [4];
    logic signed [DW-1:0] r4_b0min, r4_b0max, r4_b1min, r4_b1max;
    logic                 r4_sep2, r4_sep3;
    logic [3:0]           r4_use;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r4_d0[i] <= DW'(r3_m0x[i]) + DW'(r3_m0y[i]);
            r4_d1[i] <= DW'(r3_m1y[i]) - DW'(r3_m1x[i]);
        end
        r4_b0min <= min2(DW'(r3_bxc0), DW'(r3_bxc1)) + min2(DW'(r3_bys0), DW'(r3_bys1));
        r4_b0max <= max2(DW'(r3_bxc0), DW'(r3_bxc1)) + max2(DW'(r3_bys0), DW'(r3_bys1));
        r4_b1min <= min2(DW'(r3_byc0), DW'(r3_byc1)) - max2(DW'(r3_bxs0), DW'(r3_bxs1));
        r4_b1max <= max2(DW'(r3_byc0), DW'(r3_byc1)) - min2(DW'(r3_bxs0), DW'(r3_bxs1));
        r4_sep2  <= (r3_xmax < r3_bl) || (r3_br < r3_xmin);
        r4_sep3  <= (r3_ymax < r3_bt) || (r3_bb < r3_ymin);
        r4_use   <= r3_use;
    end

    // stage 5: interval ends on the rotated axes
    logic                 r5_v;
    logic signed [DW-1:0] r5_a0min, r5_a0max, r5_a1min, r5_a1max;
    logic signed [DW-1:0] r5_b0min, r5_b0max, r5_b1min, r5_b1max;
    logic                 r5_sep2, r5_sep3;
    logic [3:0]           r5_use;

    always_ff @(posedge i_clk) begin
        r5_a0min <= min2(min2(r4_d0[0], r4_d0[1]), min2(r4_d0[2], r4_d0[3]));
        r5_a0max <= max2(max2(r4_d0[0], r4_d0[1]), max2(r4_d0[2], r4_d0[3]));
        r5_a1min <= min2(min2(r4_d1[0], r4_d1[1]), min2(r4_d1[2], r4_d1[3]));
        r5_a1max <= max2(max2(r4_d1[0], r4_d1[1]), max2(r4_d1[2], r4_d1[3]));
        r5_b0min <= r4_b0min <<< 15;
        r5_b0max <= r4_b0max <<< 15;
        r5_b1min <= r4_b1min <<< 15;
        r5_b1max <= r4_b1max <<< 15;
        r5_sep2  <= r4_sep2;
        r5_sep3  <= r4_sep3;
        r5_use   <= r4_use;
    end

    // stage 6: verdict
    logic w_sep0, w_sep1;
    logic r6_v;
    logic r6_overlap;

    assign w_sep0 = (r5_a0max < r5_b0min) || (r5_b0max < r5_a0min);
    assign w_sep1 = (r5_a1max < r5_b1min) || (r5_b1max < r5_a1min);

    always_ff @(posedge i_clk) begin
        r6_overlap <= !((r5_use[0] && w_sep0) || (r5_use[1] && w_sep1) ||
                        (r5_use[2] && r5_sep2) || (r5_use[3] && r5_sep3));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    assign o_strobe  = r6_v;
    assign o_overlap = r6_overlap;

endmodule
